// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the scheduler datapath; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- hdl/mlfq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler package
// Field widths, parameter defaults and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package mlfq_pkg;
    localparam int JOBS_DEF      = 16;
    localparam int LEVELS_DEF    = 8;
    localparam int TIME_BITS_DEF = 16;

    localparam int ID_W    = 4;
    localparam int SVC_W   = 16;
    localparam int RLV_W   = 3;
    localparam int OTIME_W = 16;

    typedef struct packed {
        logic capture;
        logic do_arrive;
        logic do_pre;
        logic do_pop;
        logic do_load;
        logic do_run;
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic out_full;
    } st_t;
endpackage

// ----- hdl/mlfq_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler input channel
// Valid/ready channel that carries arrive and tick items.
// ----------------------------------------------------------------------------
interface mlfq_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [mlfq_pkg::ID_W-1:0]    job_id;
    logic [mlfq_pkg::SVC_W-1:0]   service_time;

    modport source (output valid, action, job_id, service_time, input ready);
    modport sink   (input valid, action, job_id, service_time, output ready);
endinterface

// ----- hdl/mlfq_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel that carries one result per tick.
// ----------------------------------------------------------------------------
interface mlfq_out_if;
    logic                          valid;
    logic                          ready;
    logic                          busy_res;
    logic [mlfq_pkg::ID_W-1:0]     running_id;
    logic [mlfq_pkg::RLV_W-1:0]    run_level;
    logic                          finished;
    logic [mlfq_pkg::OTIME_W-1:0]  finish_time;
    logic [mlfq_pkg::OTIME_W-1:0]  turnaround;

    modport source (output valid, busy_res, running_id, run_level, finished,
                    finish_time, turnaround, input ready);
    modport sink   (input valid, busy_res, running_id, run_level, finished,
                    finish_time, turnaround, output ready);
endinterface

// ----- hdl/mlfq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/mlfq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences arrive and tick items through the datapath.
// ----------------------------------------------------------------------------
module mlfq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_action,
    input  mlfq_pkg::st_t   st,
    output logic            in_ready,
    output mlfq_pkg::cmd_t  cmd
);
    import mlfq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ARR  = 3'd1;
    localparam logic [2:0] S_PRE  = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_RUN  = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = in_action ? S_PRE : S_ARR;
                end
            end
            S_ARR:
            begin
                cmd.do_arrive = 1'b1;
                state_next    = S_IDLE;
            end
            S_PRE:
            begin
                cmd.do_pre = 1'b1;
                state_next = st.pop ? S_POP : S_RUN;
            end
            S_POP:
            begin
                cmd.do_pop = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.do_load = 1'b1;
                state_next  = S_RUN;
            end
            S_RUN:
            begin
                if (!st.out_full)
                begin
                    cmd.do_run = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ----- hdl/mlfq_dp.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Scheduler datapath
// Level FIFOs, job table, running job cache, tick counter and result register.
// ----------------------------------------------------------------------------
module mlfq_dp #(
    parameter int JOBS      = mlfq_pkg::JOBS_DEF,
    parameter int LEVELS    = mlfq_pkg::LEVELS_DEF,
    parameter int TIME_BITS = mlfq_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mlfq_pkg::cmd_t                cmd,
    output mlfq_pkg::st_t                 st,
    input  logic                          in_action,
    input  logic [mlfq_pkg::ID_W-1:0]     in_job_id,
    input  logic [mlfq_pkg::SVC_W-1:0]    in_service_time,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          busy_res,
    output logic [mlfq_pkg::ID_W-1:0]     running_id,
    output logic [mlfq_pkg::RLV_W-1:0]    run_level,
    output logic                          finished,
    output logic [mlfq_pkg::OTIME_W-1:0]  finish_time,
    output logic [mlfq_pkg::OTIME_W-1:0]  turnaround
);
    import mlfq_pkg::*;

    localparam int JOB_W  = $clog2(JOBS);
    localparam int LV_W   = $clog2(LEVELS);
    localparam int FILL_W = $clog2(JOBS + 1);
    localparam int SL_W   = LEVELS + 1;
    localparam int TAB_W  = SVC_W + TIME_BITS + LV_W;
    localparam int QA_W   = LV_W + JOB_W;

    function automatic logic [JOB_W-1:0] nxt(input logic [JOB_W-1:0] p);
        return (p == JOB_W'(JOBS - 1)) ? '0 : p + 1'b1;
    endfunction

    // Captured input item.
    logic                 act_reg;
    logic [ID_W-1:0]      id_reg;
    logic [SVC_W-1:0]     svc_reg;

    logic [JOB_W-1:0]     head_reg [LEVELS];
    logic [JOB_W-1:0]     tail_reg [LEVELS];
    logic [FILL_W-1:0]    fill_reg [LEVELS];

    // Running job and its cached table entry.
    logic                 busy_reg;
    logic [JOB_W-1:0]     cur_job_reg;
    logic [SVC_W-1:0]     cur_left_reg;
    logic [TIME_BITS-1:0] cur_stamp_reg;
    logic [LV_W-1:0]      cur_lv_reg;
    logic [LEVELS-1:0]    slice_reg;
    logic [TIME_BITS-1:0] tick_reg;
    logic                 out_valid_reg;

    logic [LEVELS-1:0]    nonempty;
    logic                 any_ne, higher_ne, preempt, pop_go;
    logic [LV_W-1:0]      pop_lv;
    logic                 id_ok;
    logic [JOB_W-1:0]     id_job;
    logic                 svc_done, expire;
    logic [SL_W-1:0]      slice_inc, quantum;
    logic [LV_W-1:0]      new_lv;
    logic [TIME_BITS-1:0] fin, tat;

    logic                 push_en, push_ok;
    logic [LV_W-1:0]      push_lv;
    logic [JOB_W-1:0]     push_job;

    logic                 t_we;
    logic [JOB_W-1:0]     t_waddr;
    logic [TAB_W-1:0]     t_wdata, t_rdata;
    logic [JOB_W-1:0]     q_rdata;

    assign id_ok  = int'(id_reg) < JOBS;
    assign id_job = JOB_W'(id_reg);

    always_comb
    begin
        any_ne    = 1'b0;
        higher_ne = 1'b0;
        pop_lv    = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            nonempty[l] = (fill_reg[l] != '0);
            if (nonempty[l])
            begin
                pop_lv = LV_W'(l);
                any_ne = 1'b1;
                if (LV_W'(l) < cur_lv_reg)
                begin
                    higher_ne = 1'b1;
                end
            end
        end
    end

    assign preempt = busy_reg && higher_ne;
    assign st.pop  = (!busy_reg || preempt) && any_ne;
    assign st.out_full = out_valid_reg && !out_ready;
    assign pop_go  = cmd.do_pre && st.pop;

    assign svc_done  = (cur_left_reg <= SVC_W'(1));
    assign slice_inc = {1'b0, slice_reg} + 1'b1;
    assign quantum   = SL_W'(1) << cur_lv_reg;
    assign expire    = (slice_inc >= quantum);
    assign new_lv    = (cur_lv_reg == LV_W'(LEVELS - 1)) ? cur_lv_reg : cur_lv_reg + 1'b1;
    assign fin       = tick_reg + 1'b1;
    assign tat       = fin - cur_stamp_reg;

    always_comb
    begin
        push_en  = 1'b0;
        push_lv  = '0;
        push_job = cur_job_reg;
        t_we     = 1'b0;
        t_waddr  = cur_job_reg;
        t_wdata  = {cur_left_reg, cur_stamp_reg, cur_lv_reg};
        if (cmd.do_arrive && id_ok)
        begin
            push_en  = 1'b1;
            push_job = id_job;
            t_we     = 1'b1;
            t_waddr  = id_job;
            t_wdata  = {svc_reg, tick_reg, LV_W'(0)};
        end
        else if (cmd.do_pre && preempt)
        begin
            push_en = 1'b1;
            push_lv = cur_lv_reg;
            t_we    = 1'b1;
        end
        else if (cmd.do_run && busy_reg)
        begin
            if (svc_done)
            begin
                t_we    = 1'b1;
                t_wdata = {SVC_W'(0), cur_stamp_reg, cur_lv_reg};
            end
            else if (expire)
            begin
                push_en = 1'b1;
                push_lv = new_lv;
                t_we    = 1'b1;
                t_wdata = {cur_left_reg - 1'b1, cur_stamp_reg, new_lv};
            end
        end
    end

    // A push into a full level is dropped.
    assign push_ok = push_en && (fill_reg[push_lv] < FILL_W'(JOBS));

    mlfq_ram #(.WIDTH(JOB_W), .DEPTH(LEVELS << JOB_W)) u_qram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (QA_W'({push_lv, tail_reg[push_lv]})),
        .wdata (push_job),
        .raddr (QA_W'({pop_lv, head_reg[pop_lv]})),
        .rdata (q_rdata)
    );

    mlfq_ram #(.WIDTH(TAB_W), .DEPTH(JOBS)) u_tab (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (q_rdata),
        .rdata (t_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                fill_reg[l] <= '0;
            end
            busy_reg      <= 1'b0;
            cur_job_reg   <= '0;
            slice_reg     <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                if (pop_go && pop_lv == LV_W'(l))
                begin
                    head_reg[l] <= nxt(head_reg[l]);
                end
                if (push_ok && push_lv == LV_W'(l))
                begin
                    tail_reg[l] <= nxt(tail_reg[l]);
                end
                fill_reg[l] <= fill_reg[l]
                             + FILL_W'(push_ok && push_lv == LV_W'(l))
                             - FILL_W'(pop_go && pop_lv == LV_W'(l));
            end
            if (cmd.do_pre && preempt)
            begin
                busy_reg <= 1'b0;
            end
            if (cmd.do_pop)
            begin
                cur_job_reg <= q_rdata;
            end
            if (cmd.do_load)
            begin
                busy_reg  <= 1'b1;
                slice_reg <= '0;
            end
            if (cmd.do_run)
            begin
                tick_reg <= tick_reg + 1'b1;
                if (busy_reg)
                begin
                    slice_reg <= slice_inc[LEVELS-1:0];
                    if (svc_done || expire)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
            end
            if (cmd.do_run)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= in_action;
            id_reg  <= in_job_id;
            svc_reg <= in_service_time;
        end
        if (cmd.do_load)
        begin
            {cur_left_reg, cur_stamp_reg, cur_lv_reg} <= t_rdata;
        end
        // A new arrive of the running id rewrites the running job's entry too.
        if (cmd.do_arrive && id_ok && busy_reg && id_job == cur_job_reg)
        begin
            cur_left_reg  <= svc_reg;
            cur_stamp_reg <= tick_reg;
            cur_lv_reg    <= '0;
        end
        if (cmd.do_run && busy_reg && !svc_done)
        begin
            cur_left_reg <= cur_left_reg - 1'b1;
        end
        if (cmd.do_run)
        begin
            busy_res    <= busy_reg;
            running_id  <= busy_reg ? ID_W'(cur_job_reg) : '0;
            run_level   <= busy_reg ? RLV_W'(cur_lv_reg) : '0;
            finished    <= busy_reg && svc_done;
            finish_time <= (busy_reg && svc_done) ? OTIME_W'(fin) : '0;
            turnaround  <= (busy_reg && svc_done) ? OTIME_W'(tat) : '0;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_CLK(a_load_busy, cmd.do_load |=> busy_reg, "dispatch did not start the job")
    `ASSERT_CLK(a_done_idle, (cmd.do_run && busy_reg && svc_done) |=> !busy_reg, "cpu kept")
    `ASSERT_CLK(a_tick_step, cmd.do_run |=> (tick_reg == TIME_BITS'($past(tick_reg) + 1'b1)), "tick")
    `ASSERT_CLK(a_out_src, $rose(out_valid_reg) |-> $past(cmd.do_run), "result appeared without a run")
    `ASSERT_NEVER(a_arr_tick, cmd.do_arrive && act_reg, "arrive step on a tick item")
endmodule

// ----- hdl/multilevel_feedback_scheduler_top.sv -----
`timescale 1ns / 1ps
// Steps: an arrive is captured, then pushed; a tick is captured, checked for preemption,
// then queue RAM, then job table read on dispatch; run waits for the result register.
// Throughput: one item at a time; the next item is taken when the controller is idle.
// Reset: rst_n clears all level FIFO pointers, the cpu state and the tick counter at once;
// the job table and queue memories are not cleared.
// ----------------------------------------------------------------------------
// Multilevel feedback scheduler top level
// Controller and datapath joined to the input and result channels.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_top #(
    parameter int JOBS      = mlfq_pkg::JOBS_DEF,
    parameter int LEVELS    = mlfq_pkg::LEVELS_DEF,
    parameter int TIME_BITS = mlfq_pkg::TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mlfq_in_if.sink     in_ch,
    mlfq_out_if.source  out_ch
);
    import mlfq_pkg::*;

    cmd_t cmd;
    st_t  st;

    mlfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .st        (st),
        .in_ready  (in_ch.ready),
        .cmd       (cmd)
    );

    mlfq_dp #(.JOBS(JOBS), .LEVELS(LEVELS), .TIME_BITS(TIME_BITS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .in_action       (in_ch.action),
        .in_job_id       (in_ch.job_id),
        .in_service_time (in_ch.service_time),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .busy_res        (out_ch.busy_res),
        .running_id      (out_ch.running_id),
        .run_level       (out_ch.run_level),
        .finished        (out_ch.finished),
        .finish_time     (out_ch.finish_time),
        .turnaround      (out_ch.turnaround)
    );
endmodule

// ----- tb/mlfq_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler prediction package
// Holds a cycle-free model of the feedback scheduler and a small scoreboard
// that checks each result transfer against the oldest predicted tick.
// ----------------------------------------------------------------------------
package mlfq_tb_pkg;
    import mlfq_pkg::*;

    localparam int NJOBS   = JOBS_DEF;
    localparam int NLEVELS = LEVELS_DEF;

    typedef enum logic { ACT_ARRIVE = 1'b0, ACT_TICK = 1'b1 } action_e;

    typedef struct packed {
        logic               busy_res;
        logic [ID_W-1:0]    running_id;
        logic [RLV_W-1:0]   run_level;
        logic               finished;
        logic [OTIME_W-1:0] finish_time;
        logic [OTIME_W-1:0] turnaround;
    } tick_res_t;

    class sched_scoreboard;
        logic [ID_W-1:0]  fifo_slot [NLEVELS][NJOBS];
        int               head_pos [NLEVELS];
        int               tail_pos [NLEVELS];
        int               fill_cnt [NLEVELS];
        logic [15:0]      remaining [NJOBS];
        logic [15:0]      stamp [NJOBS];
        int               level_of [NJOBS];
        int               cur_job;
        bit               running;
        int               slice_cnt;
        logic [15:0]      now;
        tick_res_t        pending [$];
        int               errors;

        function new();
            for (int l = 0; l < NLEVELS; l++)
            begin
                head_pos[l] = 0;
                tail_pos[l] = 0;
                fill_cnt[l] = 0;
            end
            cur_job = 0;
            running = 0;
            slice_cnt = 0;
            now = 0;
            errors = 0;
        endfunction

        function void enqueue(int lv, int job);
            if (fill_cnt[lv] >= NJOBS)
                return;
            fifo_slot[lv][tail_pos[lv]] = ID_W'(job);
            tail_pos[lv] = (tail_pos[lv] + 1) % NJOBS;
            fill_cnt[lv]++;
        endfunction

        function int dequeue(int lv);
            int job;
            job = fifo_slot[lv][head_pos[lv]];
            head_pos[lv] = (head_pos[lv] + 1) % NJOBS;
            fill_cnt[lv]--;
            return job;
        endfunction

        // Notes one accepted input transfer and, for a tick, predicts its result.
        function void note_input(logic act, logic [ID_W-1:0] id, logic [SVC_W-1:0] svc);
            tick_res_t r;
            int lv;
            int my;
            r = '0;
            if (act == ACT_ARRIVE)
            begin
                remaining[id] = svc;
                stamp[id] = now;
                level_of[id] = 0;
                enqueue(0, id);
                return;
            end
            if (running)
            begin
                my = level_of[cur_job];
                for (int l = 0; l < my; l++)
                    if (running && fill_cnt[l] != 0)
                    begin
                        enqueue(my, cur_job);
                        running = 0;
                    end
            end
            if (!running)
                for (int l = 0; l < NLEVELS; l++)
                    if (!running && fill_cnt[l] != 0)
                    begin
                        cur_job = dequeue(l);
                        running = 1;
                        slice_cnt = 0;
                    end
            if (running)
            begin
                lv = level_of[cur_job];
                r.busy_res = 1;
                r.running_id = ID_W'(cur_job);
                r.run_level = RLV_W'(lv);
                if (remaining[cur_job] <= 1)
                begin
                    remaining[cur_job] = 0;
                    running = 0;
                    r.finished = 1;
                    r.finish_time = now + 16'd1;
                    r.turnaround = r.finish_time - stamp[cur_job];
                end
                else
                begin
                    remaining[cur_job]--;
                    slice_cnt++;
                    if (slice_cnt >= (1 << lv))
                    begin
                        running = 0;
                        if (lv + 1 < NLEVELS)
                            lv++;
                        level_of[cur_job] = lv;
                        enqueue(lv, cur_job);
                    end
                end
            end
            now = now + 16'd1;
            pending.insert(pending.size(), r);
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            errors++;
            $display("mismatch %s: got %0d expected %0d", what, got, want);
        endtask

        task check_result(tick_res_t got);
            tick_res_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result", '0, '0);
                return;
            end
            w = pending.pop_front();
            if (got.busy_res !== w.busy_res)
                report("busy_res", 16'(got.busy_res), 16'(w.busy_res));
            if (got.running_id !== w.running_id)
                report("running_id", 16'(got.running_id), 16'(w.running_id));
            if (got.run_level !== w.run_level)
                report("run_level", 16'(got.run_level), 16'(w.run_level));
            if (got.finished !== w.finished)
                report("finished", 16'(got.finished), 16'(w.finished));
            if (got.finish_time !== w.finish_time)
                report("finish_time", got.finish_time, w.finish_time);
            if (got.turnaround !== w.turnaround)
                report("turnaround", got.turnaround, w.turnaround);
        endtask
    endclass
endpackage

// ----- tb/multilevel_feedback_scheduler_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback scheduler testbench
// Drives arrive and tick transfers with random gaps and output stalls, and
// checks every tick result against a predicted schedule.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_top_tb;
    import mlfq_pkg::*;
    import mlfq_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   cycles;
    bit   gaps_on;
    bit   hold_off;
    bit   sink_steady;

    mlfq_in_if  in_ch ();
    mlfq_out_if out_ch ();

    sched_scoreboard board;

    multilevel_feedback_scheduler_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sample both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            board.note_input(in_ch.action, in_ch.job_id, in_ch.service_time);
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result({out_ch.busy_res, out_ch.running_id, out_ch.run_level,
                                out_ch.finished, out_ch.finish_time, out_ch.turnaround});
    end

    // Result side: random stalls, a long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_off)
            out_ch.ready <= 1'b0;
        else if (sink_steady || !gaps_on)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(99) >= 33);
    end

    task send(logic act, logic [ID_W-1:0] id, logic [SVC_W-1:0] svc);
        if (gaps_on)
            while ($urandom_range(99) < 33)
            begin
                in_ch.valid = 1'b0;
                @(negedge clk);
            end
        in_ch.valid        = 1'b1;
        in_ch.action       = act;
        in_ch.job_id       = id;
        in_ch.service_time = svc;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task arrive(logic [ID_W-1:0] id, logic [SVC_W-1:0] svc);
        send(ACT_ARRIVE, id, svc);
    endtask

    task tick();
        send(ACT_TICK, ID_W'($urandom), SVC_W'($urandom));
    endtask

    task drain();
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    task random_item(int span);
        int r;
        logic [SVC_W-1:0] svc;
        r = $urandom_range(99);
        if (r < 22)
        begin
            case ($urandom_range(3))
                0: svc = SVC_W'($urandom);
                1: svc = SVC_W'($urandom_range(1, 40));
                2: svc = SVC_W'($urandom_range(0, 3));
                default: svc = SVC_W'($urandom_range(1, span));
            endcase
            arrive(ID_W'($urandom_range(NJOBS - 1)), svc);
        end
        else
            tick();
    endtask

    initial
    begin
        board = new();
        cycles = 0;
        gaps_on = 0;
        hold_off = 0;
        sink_steady = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_TICK;
        in_ch.job_id = '0;
        in_ch.service_time = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle tick, zero and one service, extremes, preemption, demotion.
        tick();
        arrive(4'd0, 16'd0);
        tick();
        arrive(4'd15, 16'hFFFF);
        arrive(4'd1, 16'd1);
        arrive(4'd2, 16'd20);
        repeat (6) tick();
        arrive(4'd3, 16'd3);
        arrive(4'd15, 16'd2);
        repeat (8) tick();

        // Fill level 0 past its depth so the overflow push is dropped.
        for (int i = 0; i < NJOBS + 2; i++)
            arrive(ID_W'(i % NJOBS), 16'd1);
        drain();

        // Long output hold-off while input keeps coming; then steady run.
        fork
            begin
                hold_off = 1;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            repeat (60) tick();
        join
        for (int i = 0; i < 200; i++)
            random_item(12);
        drain();

        // Random with gaps; a pause until every result has arrived midway.
        gaps_on = 1;
        for (int i = 0; i < 1550; i++)
        begin
            if (i == 700)
                drain();
            sink_steady = (i >= 900 && i < 1000);
            random_item((i % 300 < 150) ? 8 : 600);
        end
        sink_steady = 0;
        drain();
        repeat (20) @(negedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mlfq_pkg.sv
hdl/mlfq_in_if.sv
hdl/mlfq_out_if.sv
hdl/mlfq_ram.sv
hdl/mlfq_ctrl.sv
hdl/mlfq_dp.sv
hdl/multilevel_feedback_scheduler_top.sv
tb/mlfq_tb_pkg.sv
tb/multilevel_feedback_scheduler_top_tb.sv
